// ===== rtl/ipv4_longest_prefix_route_lookup_defines.svh =====
// Assertion macros for the route lookup engine.
// Included by the top level; relies on ports named clock and reset.
`ifndef IPV4_LONGEST_PREFIX_ROUTE_LOOKUP_DEFINES_SVH
`define IPV4_LONGEST_PREFIX_ROUTE_LOOKUP_DEFINES_SVH

// Property checked in the same cycle as its trigger
`define IPLPR_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Antecedent in one cycle, consequent in the next
`define IPLPR_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/iplpr_pkg.sv =====
// Shared types and constants of the route lookup engine.
// Used by iplpr_cell, the top level and tb_top; depends on nothing.
`default_nettype none

package iplpr_pkg;

   // table geometry
   localparam int ROUTES = 64;
   localparam int LANES  = 4;
   localparam int CELLS  = ROUTES / LANES;
   localparam int IDX_W  = $clog2(ROUTES);
   localparam int LANE_W = $clog2(LANES);
   localparam int CELL_W = IDX_W - LANE_W;

   // field widths
   localparam int ADDR_W  = 32;
   localparam int PORT_W  = 4;
   localparam int COUNT_W = 7;

   // stream and register port widths
   localparam int REQ_TDATA_W = 144;
   localparam int RSP_TDATA_W = 48;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_SEL_W   = CSR_ADDR_W - 2;

   // register word indexes
   localparam logic [CSR_SEL_W-1:0] REG_ROUTE_COUNT = '0;

   typedef enum logic [0:0] {
      FUNC_WRITE  = 1'b0,
      FUNC_LOOKUP = 1'b1
   } func_type;

   // table write broadcast to every cell
   typedef struct packed {
      logic              en;
      logic [IDX_W-1:0]  index;
      logic [ADDR_W-1:0] prefix;
      logic [ADDR_W-1:0] mask;
      logic [ADDR_W-1:0] hop;
      logic [PORT_W-1:0] port;
   } wr_type;

   // search token handed along the chain
   typedef struct packed {
      logic              valid;
      logic [ADDR_W-1:0] dest;
      logic              found;
      logic [ADDR_W-1:0] mask;
      logic [IDX_W-1:0]  index;
      logic [ADDR_W-1:0] hop;
      logic [PORT_W-1:0] port;
   } tok_type;

endpackage

`default_nettype wire

// ===== rtl/ipv4_longest_prefix_route_lookup.sv =====
// Top level of the IPv4 longest-prefix route lookup engine: stream ports,
// register port, search chain of iplpr_cell and result register.
// Depends on iplpr_pkg, iplpr_cell and the assertion macro header.
//
//  Channel   | Direction | Handshake              | Carries
//  req_      | in        | tvalid / tready        | route write or lookup item
//  rsp_      | out       | tvalid / tready        | lookup result, none for writes
//  csr_      | in        | psel / penable, pready | route_count register
//
//  Write items do not set busy and are taken back to back. A lookup runs through
//  CELLS = 16 chained cells (four entries each), one cell per cycle, and the next
//  item is taken once its result is loaded into the result register.
//  A result left untaken holds the token at the chain tail until rsp_tready.
//  Reset clears route_count, the chain valid bits and the result valid;
//  table entries are undefined until written.
`default_nettype none

`include "ipv4_longest_prefix_route_lookup_defines.svh"

module ipv4_longest_prefix_route_lookup (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // request stream
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // tdata: entry_index[5:0], entry_prefix[37:6], entry_mask[69:38],
   //        entry_next_hop[101:70], entry_port[105:102], dest_addr[137:106], zero pad
   input  wire logic [iplpr_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // tuser: func[0]
   input  wire logic                                 req_tuser,
   // result stream
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // tdata: hop_addr[31:0], out_port[35:32], best_index[41:36], zero pad
   output logic [iplpr_pkg::RSP_TDATA_W-1:0]         rsp_tdata,
   // tuser: route_found[0]
   output logic                                      rsp_tuser,
   // register port
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [iplpr_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [iplpr_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [iplpr_pkg::CSR_DATA_W-1:0]          csr_prdata,
   output logic                                      csr_pready
);

   localparam int IDX_LO    = 0;
   localparam int PREFIX_LO = IDX_LO + iplpr_pkg::IDX_W;
   localparam int MASK_LO   = PREFIX_LO + iplpr_pkg::ADDR_W;
   localparam int HOP_LO    = MASK_LO + iplpr_pkg::ADDR_W;
   localparam int PORT_LO   = HOP_LO + iplpr_pkg::ADDR_W;
   localparam int DEST_LO   = PORT_LO + iplpr_pkg::PORT_W;
   localparam int RSP_USED  = iplpr_pkg::ADDR_W + iplpr_pkg::PORT_W + iplpr_pkg::IDX_W;

   logic [iplpr_pkg::COUNT_W-1:0] route_count_ff;
   logic                          busy_ff;
   logic                          rsp_valid_ff;
   logic                          rsp_found_ff;
   logic [iplpr_pkg::ADDR_W-1:0]  rsp_hop_ff;
   logic [iplpr_pkg::PORT_W-1:0]  rsp_port_ff;
   logic [iplpr_pkg::IDX_W-1:0]   rsp_index_ff;

   logic                          req_xfer;
   logic                          csr_wr;
   logic                          chain_en;
   logic                          rsp_load;
   iplpr_pkg::func_type           req_func;
   iplpr_pkg::wr_type             wr;
   iplpr_pkg::tok_type            chain_tok [iplpr_pkg::CELLS+1];
   iplpr_pkg::tok_type            tail;

   // register port: single word, always ready
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         route_count_ff <= '0;
      end else if (csr_wr && (csr_paddr[iplpr_pkg::CSR_ADDR_W-1:2] == iplpr_pkg::REG_ROUTE_COUNT)) begin
         route_count_ff <= csr_pwdata[iplpr_pkg::COUNT_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[iplpr_pkg::CSR_ADDR_W-1:2] == iplpr_pkg::REG_ROUTE_COUNT) begin
         csr_prdata = iplpr_pkg::CSR_DATA_W'(route_count_ff);
      end
   end

   // request side: one item at a time
   assign req_tready = !busy_ff;
   assign req_xfer   = req_tvalid && req_tready;
   assign req_func   = iplpr_pkg::func_type'(req_tuser);

   // table write broadcast
   always_comb begin
      wr.en     = req_xfer && (req_func == iplpr_pkg::FUNC_WRITE);
      wr.index  = req_tdata[PREFIX_LO-1:IDX_LO];
      wr.prefix = req_tdata[MASK_LO-1:PREFIX_LO];
      wr.mask   = req_tdata[HOP_LO-1:MASK_LO];
      wr.hop    = req_tdata[PORT_LO-1:HOP_LO];
      wr.port   = req_tdata[DEST_LO-1:PORT_LO];
   end

   // head token: fresh lookup with no match yet
   always_comb begin
      chain_tok[0].valid = req_xfer && (req_func == iplpr_pkg::FUNC_LOOKUP);
      chain_tok[0].dest  = req_tdata[DEST_LO+iplpr_pkg::ADDR_W-1:DEST_LO];
      chain_tok[0].found = 1'b0;
      chain_tok[0].mask  = '0;
      chain_tok[0].index = '0;
      chain_tok[0].hop   = '0;
      chain_tok[0].port  = '0;
   end

   // search chain
   for (genvar c = 0; c < iplpr_pkg::CELLS; c++) begin : g_cell
      iplpr_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .enable      (chain_en),
         .cell_id     (iplpr_pkg::CELL_W'(c)),
         .route_count (route_count_ff),
         .wr          (wr),
         .tok_prev    (chain_tok[c]),
         .tok_next    (chain_tok[c+1])
      );
   end

   assign tail = chain_tok[iplpr_pkg::CELLS];

   // tail hands over when the result register is free or being emptied
   assign rsp_load = tail.valid && (!rsp_valid_ff || rsp_tready);
   assign chain_en = !tail.valid || rsp_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (chain_tok[0].valid) begin
         busy_ff <= 1'b1;
      end else if (rsp_load) begin
         busy_ff <= 1'b0;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_found_ff <= tail.found;
         rsp_hop_ff   <= tail.hop;
         rsp_port_ff  <= tail.port;
         rsp_index_ff <= tail.index;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tdata  = {(iplpr_pkg::RSP_TDATA_W - RSP_USED)'(0),
                        rsp_index_ff, rsp_port_ff, rsp_hop_ff};

   // checks
   `IPLPR_ASSERT(a_rsp_from_lookup, $rose(rsp_valid_ff) |-> $past(busy_ff), "result without lookup in flight")
   `IPLPR_ASSERT(a_miss_zero, (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata == '0), "miss result not zero")
   `IPLPR_ASSERT_NEXT(a_lookup_enters, chain_tok[0].valid, busy_ff && chain_tok[1].valid, "lookup did not enter chain")

endmodule

`default_nettype wire

// ===== rtl/iplpr_cell.sv =====
// One cell of the search chain: holds LANES route entries and refines the
// passing best-match token against them. Depends on iplpr_pkg.
`default_nettype none

module iplpr_cell (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           enable,
   input  wire logic [iplpr_pkg::CELL_W-1:0]   cell_id,
   input  wire logic [iplpr_pkg::COUNT_W-1:0]  route_count,
   input  wire iplpr_pkg::wr_type              wr,
   input  wire iplpr_pkg::tok_type             tok_prev,
   output iplpr_pkg::tok_type                  tok_next
);

   logic [iplpr_pkg::ADDR_W-1:0] prefix_ff [iplpr_pkg::LANES];
   logic [iplpr_pkg::ADDR_W-1:0] mask_ff   [iplpr_pkg::LANES];
   logic [iplpr_pkg::ADDR_W-1:0] hop_ff    [iplpr_pkg::LANES];
   logic [iplpr_pkg::PORT_W-1:0] port_ff   [iplpr_pkg::LANES];

   iplpr_pkg::tok_type tok_ff;
   iplpr_pkg::tok_type tok_in;

   logic wr_here;

   // entry storage: written by a broadcast addressed to this cell
   assign wr_here = wr.en && (wr.index[iplpr_pkg::IDX_W-1:iplpr_pkg::LANE_W] == cell_id);

   always_ff @(posedge clock) begin
      if (wr_here) begin
         prefix_ff[wr.index[iplpr_pkg::LANE_W-1:0]] <= wr.prefix;
         mask_ff[wr.index[iplpr_pkg::LANE_W-1:0]]   <= wr.mask;
         hop_ff[wr.index[iplpr_pkg::LANE_W-1:0]]    <= wr.hop;
         port_ff[wr.index[iplpr_pkg::LANE_W-1:0]]   <= wr.port;
      end
   end

   // compare lanes in slot order; strictly greater mask wins, so ties keep
   // the lower slot
   always_comb begin
      logic [iplpr_pkg::IDX_W-1:0] idx;
      logic                        active;
      logic                        hit;
      tok_in = tok_prev;
      for (int l = 0; l < iplpr_pkg::LANES; l++) begin
         idx    = {cell_id, iplpr_pkg::LANE_W'(l)};
         active = iplpr_pkg::COUNT_W'(idx) < route_count;
         hit    = active && ((tok_prev.dest & mask_ff[l]) == prefix_ff[l])
                  && (!tok_in.found || (mask_ff[l] > tok_in.mask));
         if (hit) begin
            tok_in.found = 1'b1;
            tok_in.mask  = mask_ff[l];
            tok_in.index = idx;
            tok_in.hop   = hop_ff[l];
            tok_in.port  = port_ff[l];
         end
      end
   end

   // token register towards the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else if (enable) begin
         tok_ff <= tok_in;
      end
   end

   assign tok_next = tok_ff;

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the IPv4 longest-prefix route lookup engine.
// Depends on iplpr_pkg and ipv4_longest_prefix_route_lookup; keeps a shadow
// route table and predicts every lookup result from it.
module tb_top;
   import iplpr_pkg::*;

   localparam int LOOKUP_CYCLES = CELLS + 2;
   localparam int SETTLE_CYCLES = LOOKUP_CYCLES + 8;
   localparam int MAX_REPORTS   = 10;
   localparam logic [CSR_ADDR_W-1:0] ROUTE_COUNT_ADDR = {REG_ROUTE_COUNT, 2'b00};

   // one request transfer, fields as carried on req_
   typedef struct packed {
      func_type          func;
      logic [IDX_W-1:0]  index;
      logic [ADDR_W-1:0] prefix;
      logic [ADDR_W-1:0] mask;
      logic [ADDR_W-1:0] hop;
      logic [PORT_W-1:0] port;
      logic [ADDR_W-1:0] dest;
   } route_req_type;

   // one lookup answer, fields as carried on rsp_
   typedef struct packed {
      logic              found;
      logic [ADDR_W-1:0] hop;
      logic [PORT_W-1:0] port;
      logic [IDX_W-1:0]  index;
   } route_ans_type;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_tvalid  = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata   = '0;
   logic                   req_tuser   = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready  = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;
   logic                   csr_psel    = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_paddr   = '0;
   logic [CSR_DATA_W-1:0]  csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   // shadow route table and register
   logic [ADDR_W-1:0]  shadow_prefix [ROUTES];
   logic [ADDR_W-1:0]  shadow_mask   [ROUTES];
   logic [ADDR_W-1:0]  shadow_hop    [ROUTES];
   logic [PORT_W-1:0]  shadow_port   [ROUTES];
   logic               slot_written  [ROUTES];
   logic [COUNT_W-1:0] shadow_count = '0;

   route_ans_type answers_due [$];
   int         mismatches   = 0;
   int         burst_left   = 0;
   logic [7:0] stall_pattern = 8'hFF;
   int         stall_age     = 0;

   ipv4_longest_prefix_route_lookup uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------

   // exact longest-prefix match over the searched slots, lowest slot on a tie
   function automatic route_ans_type best_route(input logic [ADDR_W-1:0] dest);
      route_ans_type     ans;
      logic [ADDR_W-1:0] best_mask;
      int                best_slot;
      int                span;
      ans       = '0;
      best_mask = '0;
      best_slot = 0;
      span      = (shadow_count < ROUTES) ? int'(shadow_count) : ROUTES;
      for (int i = 0; i < span; i++) begin
         if ((dest & shadow_mask[i]) == shadow_prefix[i] &&
             (!ans.found || shadow_mask[i] > best_mask)) begin
            ans.found = 1'b1;
            best_mask = shadow_mask[i];
            best_slot = i;
         end
      end
      if (ans.found) begin
         ans.hop   = shadow_hop[best_slot];
         ans.port  = shadow_port[best_slot];
         ans.index = IDX_W'(best_slot);
      end
      return ans;
   endfunction

   task automatic flag_mismatch(input string what, input logic [ADDR_W-1:0] want,
                                input logic [ADDR_W-1:0] got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
   endtask

   // ------------------------------------------------------------------
   // Result side: stall pattern and checker
   // ------------------------------------------------------------------

   // rotating ready pattern, replaced at random by all-ones or a random pattern
   always @(posedge clock) begin
      if (stall_age == 0) begin
         stall_age = $urandom_range(16, 80);
         if ($urandom_range(0, 2) == 0)
            stall_pattern = 8'hFF;
         else
            stall_pattern = 8'($urandom) | 8'h01;
      end
      stall_age--;
      rsp_tready <= stall_pattern[0];
      stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
   end

   // compare each result transfer with the oldest outstanding answer
   always @(posedge clock) begin
      route_ans_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (answers_due.size() == 0) begin
            flag_mismatch("unexpected result", '0, rsp_tdata[ADDR_W-1:0]);
         end else begin
            want = answers_due.pop_front();
            if (rsp_tuser !== want.found)
               flag_mismatch("route_found", ADDR_W'(want.found), ADDR_W'(rsp_tuser));
            if (rsp_tdata[31:0] !== want.hop)
               flag_mismatch("hop_addr", want.hop, rsp_tdata[31:0]);
            if (rsp_tdata[35:32] !== want.port)
               flag_mismatch("out_port", ADDR_W'(want.port), ADDR_W'(rsp_tdata[35:32]));
            if (rsp_tdata[41:36] !== want.index)
               flag_mismatch("best_index", ADDR_W'(want.index), ADDR_W'(rsp_tdata[41:36]));
         end
      end
   end

   // ------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------

   // send one item in bursts with random gaps; shadow state follows the transfer
   task automatic send_route_item(input route_req_type item);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 8);
         gap = $urandom_range(1, 24);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= item.func;
      req_tdata  <= REQ_TDATA_W'({item.dest, item.port, item.hop, item.mask,
                                  item.prefix, item.index});
      do @(posedge clock); while (!req_tready);
      if (item.func == FUNC_WRITE) begin
         shadow_prefix[item.index] = item.prefix;
         shadow_mask[item.index]   = item.mask;
         shadow_hop[item.index]    = item.hop;
         shadow_port[item.index]   = item.port;
         slot_written[item.index]  = 1'b1;
      end else begin
         answers_due.push_back(best_route(item.dest));
      end
   endtask

   function automatic route_req_type route_write(input logic [IDX_W-1:0] slot,
                                                 input logic [ADDR_W-1:0] prefix,
                                                 input logic [ADDR_W-1:0] mask,
                                                 input logic [ADDR_W-1:0] hop,
                                                 input logic [PORT_W-1:0] port);
      route_req_type item;
      item        = '0;
      item.func   = FUNC_WRITE;
      item.index  = slot;
      item.prefix = prefix;
      item.mask   = mask;
      item.hop    = hop;
      item.port   = port;
      item.dest   = $urandom;
      return item;
   endfunction

   // lookup with the unused entry fields filled with noise
   function automatic route_req_type route_lookup(input logic [ADDR_W-1:0] dest);
      route_req_type item;
      item        = route_write(IDX_W'($urandom), $urandom, $urandom, $urandom,
                                PORT_W'($urandom));
      item.func   = FUNC_LOOKUP;
      item.dest   = dest;
      return item;
   endfunction

   // random entry: overlapping heads, mostly contiguous masks, a few odd ones
   function automatic route_req_type random_route(input logic [IDX_W-1:0] slot);
      int                src;
      int                len;
      logic [ADDR_W-1:0] mask;
      logic [ADDR_W-1:0] prefix;
      src    = $urandom_range(0, ROUTES - 1);
      len    = $urandom_range(0, 32);
      mask   = (len == 0) ? '0 : (32'hFFFF_FFFF << (32 - len));
      prefix = $urandom;
      case ($urandom_range(0, 3))
         0:       prefix[31:24] = 8'h0A;
         1:       prefix[31:24] = 8'hC0;
         2:       prefix[31:24] = 8'($urandom_range(0, 3));
         default: ;
      endcase
      if ($urandom_range(0, 7) == 0)
         mask = $urandom;
      if ($urandom_range(0, 9) != 0)
         prefix = prefix & mask;
      // duplicate of another slot, so that ties get exercised
      if ($urandom_range(0, 9) == 0 && slot_written[src]) begin
         prefix = shadow_prefix[src];
         mask   = shadow_mask[src];
      end
      return route_write(slot, prefix, mask, $urandom, PORT_W'($urandom));
   endfunction

   // destination: mostly inside a searched entry, else edges and noise
   function automatic logic [ADDR_W-1:0] random_dest();
      int span;
      int src;
      span = (shadow_count < ROUTES) ? int'(shadow_count) : ROUTES;
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2, 3:    return $urandom;
         default: begin
            if (span == 0)
               return $urandom;
            src = $urandom_range(0, span - 1);
            return (shadow_prefix[src] & shadow_mask[src]) | ($urandom & ~shadow_mask[src]);
         end
      endcase
   endfunction

   // let outstanding lookups drain and the engine fall idle
   task automatic wait_until_idle();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (answers_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // register write, then read back
   task automatic set_route_count(input logic [CSR_DATA_W-1:0] value);
      logic [CSR_DATA_W-1:0] seen;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ROUTE_COUNT_ADDR;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      shadow_count = value[COUNT_W-1:0];
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      seen = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (seen[COUNT_W-1:0] !== shadow_count)
         flag_mismatch("route_count readback", ADDR_W'(shadow_count),
                       ADDR_W'(seen[COUNT_W-1:0]));
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // count of zero after reset: nothing is searched, writes still land
   task automatic test_unconfigured_table();
      send_route_item(route_lookup(32'h0000_0000));
      send_route_item(route_lookup(32'hFFFF_FFFF));
      // default route
      send_route_item(route_write(6'd0, 32'h0000_0000, 32'h0000_0000, 32'h0101_0101, 4'd1));
      // 10/8 and two 10.1/16 entries with the same prefix and mask
      send_route_item(route_write(6'd1, 32'h0A00_0000, 32'hFF00_0000, 32'h0A00_00FE, 4'd2));
      send_route_item(route_write(6'd2, 32'h0A01_0000, 32'hFFFF_0000, 32'h0A01_00FE, 4'd3));
      send_route_item(route_write(6'd3, 32'h0A01_0000, 32'hFFFF_0000, 32'h0A01_00FD, 4'd4));
      // prefix with host bits set: can never match
      send_route_item(route_write(6'd4, 32'h0A01_0203, 32'hFFFF_FF00, 32'hDEAD_BEEF, 4'd5));
      // non-contiguous mask
      send_route_item(route_write(6'd5, 32'hC0A0_0000, 32'hF0F0_F0F0, 32'hC0A0_0001, 4'd6));
      // all-ones host route, all-ones fields
      send_route_item(route_write(6'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15));
      // top slot, all-zero host route
      send_route_item(route_write(6'd63, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 4'd0));
      send_route_item(route_lookup(32'h0A01_0203));
      wait_until_idle();
   endtask

   // hand-built table: longest match, ties, odd masks, host routes
   task automatic test_special_routes();
      // upper bits of the write are dropped, leaving seven slots searched
      set_route_count(32'hFFFF_FF87);
      send_route_item(route_lookup(32'h0A01_0203));
      send_route_item(route_lookup(32'h0A02_0304));
      send_route_item(route_lookup(32'h0B00_0000));
      send_route_item(route_lookup(32'hFFFF_FFFF));
      send_route_item(route_lookup(32'hC0A5_0505));
      send_route_item(route_lookup(32'h0A01_0200));
      send_route_item(route_lookup(32'h0000_0000));
      wait_until_idle();
   endtask

   // full random table, swept over several counts with rewrites in between
   task automatic test_count_settings();
      int counts [7];
      counts = '{64, 127, 1, 0, 0, 0, 64};
      counts[3] = $urandom_range(2, 63);
      counts[4] = $urandom_range(65, 126);
      for (int s = 0; s < ROUTES; s++)
         send_route_item(random_route(IDX_W'(s)));
      foreach (counts[k]) begin
         wait_until_idle();
         set_route_count(CSR_DATA_W'(counts[k]));
         repeat (60) begin
            if ($urandom_range(0, 4) == 0)
               send_route_item(random_route(IDX_W'($urandom)));
            else
               send_route_item(route_lookup(random_dest()));
         end
      end
      wait_until_idle();
   endtask

   initial begin
      for (int s = 0; s < ROUTES; s++) begin
         shadow_prefix[s] = '0;
         shadow_mask[s]   = '0;
         shadow_hop[s]    = '0;
         shadow_port[s]   = '0;
         slot_written[s]  = 1'b0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_unconfigured_table();
      test_special_routes();
      test_count_settings();
      if (mismatches == 0 && answers_due.size() == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

   // run limit
   initial begin
      #2_000_000;
      $display("tb_top failed");
      $finish;
   end

endmodule
